### src/ilst_pkg.sv
package ilst_pkg;

  localparam int OP_W      = 2;
  localparam int IDX_W     = 5;
  localparam int DATA_W    = 32;
  localparam int STATUS_W  = 3;
  localparam int FOUND_W   = 4;
  localparam int LEN_W     = 5;
  localparam int S_TDATA_W = 40;
  localparam int M_TDATA_W = 48;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2,
    OP_FIND   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 3'd0,
    ST_FULL      = 3'd1,
    ST_BAD_INDEX = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_NULL      = 3'd4
  } status_e;

  typedef struct packed {
    logic load;
    logic match;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic slot_free;
  } sts_t;

endpackage

### src/ilst_ctrl.sv
module ilst_ctrl import ilst_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic s_tvalid_i,
  output logic s_tready_o,
  input  sts_t sts_i,
  output cmd_t cmd_o
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_WRITE
  } state_e;

  state_e state_q;
  logic   rdy_q;

  assign s_tready_o  = rdy_q;
  assign cmd_o.load   = s_tvalid_i && rdy_q;
  assign cmd_o.match  = (state_q == S_MATCH);
  assign cmd_o.commit = (state_q == S_WRITE) && sts_i.slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rdy_q   <= 1'b1;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (s_tvalid_i && rdy_q) begin
            state_q <= S_MATCH;
            rdy_q   <= 1'b0;
          end
        end
        S_MATCH: begin
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          if (sts_i.slot_free) begin
            state_q <= S_IDLE;
            rdy_q   <= 1'b1;
          end
        end
        default: begin
          state_q <= S_IDLE;
          rdy_q   <= 1'b1;
        end
      endcase
    end
  end

endmodule

### src/ilst_datapath.sv
module ilst_datapath import ilst_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  cmd_t                 cmd_i,
  output sts_t                 sts_o,
  input  logic [S_TDATA_W-1:0] s_tdata_i,
  output logic                 m_tvalid_o,
  input  logic                 m_tready_i,
  output logic [M_TDATA_W-1:0] m_tdata_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int XW = (CW > IDX_W) ? CW : IDX_W;

  op_e                    op_q;
  logic [IDX_W-1:0]       idx_q;
  logic [VALUE_WIDTH-1:0] val_q;
  logic [CW-1:0]          count_q;
  logic [VALUE_WIDTH-1:0] entries_q [DEPTH];
  logic [VALUE_WIDTH-1:0] up_w      [DEPTH];
  logic [VALUE_WIDTH-1:0] dn_w      [DEPTH];
  logic [DEPTH-1:0]       match_q, match_d;
  logic [VALUE_WIDTH-1:0] rm_q, rm_d;
  logic                   out_valid_q;
  logic [M_TDATA_W-1:0]   out_data_q;

  logic [XW-1:0]          idx_x, cnt_x, depth_x, pos_x;
  logic                   val_null, do_ins, do_rem, any_match;
  status_e                status_d;
  logic [CW-1:0]          count_d;
  logic [FOUND_W-1:0]     found_d, scan_idx;
  logic [DATA_W-1:0]      removed_d;

  assign sts_o.slot_free = !out_valid_q || m_tready_i;
  assign m_tvalid_o      = out_valid_q;
  assign m_tdata_o       = out_data_q;

  // neighbor taps of the cell row
  for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
    if (gi == 0) begin : g_first
      assign up_w[gi] = entries_q[gi];
    end else begin : g_up
      assign up_w[gi] = entries_q[gi-1];
    end
    if (gi == DEPTH - 1) begin : g_last
      assign dn_w[gi] = entries_q[gi];
    end else begin : g_dn
      assign dn_w[gi] = entries_q[gi+1];
    end
  end

  // compare all cells, pick the addressed one
  always_comb begin
    rm_d = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_d[i] = (CW'(i) < count_q) && (entries_q[i] == val_q);
      if (XW'(i) == idx_x) begin
        rm_d = entries_q[i];
      end
    end
  end

  // lowest matching position
  always_comb begin
    scan_idx = '0;
    for (int i = DEPTH - 1; i >= 0; i--) begin
      if (match_q[i]) begin
        scan_idx = FOUND_W'(i);
      end
    end
  end

  assign any_match = |match_q;
  assign idx_x     = XW'(idx_q);
  assign cnt_x     = XW'(count_q);
  assign depth_x   = XW'(DEPTH);
  assign pos_x     = (op_q == OP_PUSH) ? cnt_x : idx_x;
  assign val_null  = (val_q == '0);

  always_comb begin
    status_d  = ST_OK;
    do_ins    = 1'b0;
    do_rem    = 1'b0;
    found_d   = '0;
    removed_d = '0;
    count_d   = count_q;
    case (op_q)
      OP_PUSH, OP_INSERT: begin
        if (pos_x > cnt_x) begin
          status_d = ST_BAD_INDEX;
        end else if (val_null) begin
          status_d = ST_NULL;
        end else if (cnt_x >= depth_x) begin
          status_d = ST_FULL;
        end else begin
          do_ins  = 1'b1;
          count_d = count_q + CW'(1);
        end
      end
      OP_REMOVE: begin
        if (idx_x >= cnt_x) begin
          status_d = ST_BAD_INDEX;
        end else begin
          do_rem    = 1'b1;
          removed_d = DATA_W'(rm_q);
          count_d   = count_q - CW'(1);
        end
      end
      OP_FIND: begin
        if (val_null) begin
          status_d = ST_NULL;
        end else if (any_match) begin
          found_d = scan_idx;
        end else begin
          status_d = ST_NOT_FOUND;
        end
      end
      default: begin
        status_d = ST_OK;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q  <= op_e'(s_tdata_i[1:0]);
      idx_q <= s_tdata_i[6:2];
      val_q <= VALUE_WIDTH'(s_tdata_i[38:7]);
    end
    if (cmd_i.match) begin
      match_q <= match_d;
      rm_q    <= rm_d;
    end
    if (cmd_i.commit) begin
      out_data_q <= {4'b0, LEN_W'(count_d), found_d, removed_d, status_d};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < DEPTH; i++) begin
      if (cmd_i.commit && do_ins) begin
        if (XW'(i) > pos_x) begin
          entries_q[i] <= up_w[i];
        end else if (XW'(i) == pos_x) begin
          entries_q[i] <= val_q;
        end
      end else if (cmd_i.commit && do_rem) begin
        if (XW'(i) >= idx_x) begin
          entries_q[i] <= dn_w[i];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cmd_i.commit) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_tready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

endmodule

### src/indexed_insert_remove_list_unit.sv
// Ordered list of up to DEPTH nonzero values with push, insert at index,
// remove at index and find, one result per input transfer. The entries sit
// in a row of registers that all shift or compare at once. Each operation
// passes through the input transfer, a compare step that matches the
// value against every cell and picks the addressed entry, and a commit
// step that shifts the row, updates the length and loads the result
// register. The result register lets the next input transfer be taken while
// a result still waits; commit waits only while that register is occupied
// and not read. Entries beyond the current length never affect a result.
module indexed_insert_remove_list_unit import ilst_pkg::*; #(
  parameter int DEPTH       = 16,
  parameter int VALUE_WIDTH = 32
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // op[1:0], index[6:2], value[38:7], zero pad
  input  logic [S_TDATA_W-1:0] s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // status[2:0], removed_value[34:3], found_index[38:35], length[43:39], zero pad
  output logic [M_TDATA_W-1:0] m_axis_tdata
);

  cmd_t cmd;
  sts_t sts;

  ilst_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  ilst_datapath #(
    .DEPTH       (DEPTH),
    .VALUE_WIDTH (VALUE_WIDTH)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .sts_o      (sts),
    .s_tdata_i  (s_axis_tdata),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata)
  );

endmodule

### tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import ilst_pkg::*;

  localparam int LIST_DEPTH = 16;

  typedef struct {
    status_e              status;
    logic [DATA_W-1:0]    removed;
    logic [FOUND_W-1:0]   found;
    logic [LEN_W-1:0]     length;
  } list_result_t;

  logic                 clk_i;
  logic                 rst_ni;
  logic                 s_axis_tvalid;
  logic                 s_axis_tready;
  // op[1:0], index[6:2], value[38:7], zero pad
  logic [S_TDATA_W-1:0] s_axis_tdata;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready;
  // status[2:0], removed_value[34:3], found_index[38:35], length[43:39], zero pad
  logic [M_TDATA_W-1:0] m_axis_tdata;

  logic [DATA_W-1:0] list_vals [LIST_DEPTH];
  int                list_len;
  list_result_t      pending_results [$];
  int                fail_count;
  int                src_idle_pct;
  int                snk_stall_pct;
  bit                grow_bias;
  logic [DATA_W-1:0] value_pool [8];

  indexed_insert_remove_list_unit uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #2ms;
    $display("indexed_insert_remove_list_unit regression: fail");
    $finish;
  end

  function automatic list_result_t apply_list_op(op_e op, logic [IDX_W-1:0] idx,
                                                 logic [DATA_W-1:0] val);
    list_result_t r;
    int           pos;
    r.status  = ST_OK;
    r.removed = '0;
    r.found   = '0;
    case (op)
      OP_PUSH, OP_INSERT: begin
        pos = (op == OP_PUSH) ? list_len : int'(idx);
        if (pos > list_len) begin
          r.status = ST_BAD_INDEX;
        end else if (val == '0) begin
          r.status = ST_NULL;
        end else if (list_len >= LIST_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          for (int i = list_len; i > pos; i--) list_vals[i] = list_vals[i-1];
          list_vals[pos] = val;
          list_len++;
        end
      end
      OP_REMOVE: begin
        if (int'(idx) >= list_len) begin
          r.status = ST_BAD_INDEX;
        end else begin
          r.removed = list_vals[idx];
          for (int i = int'(idx); i + 1 < list_len; i++) list_vals[i] = list_vals[i+1];
          list_len--;
        end
      end
      default: begin
        if (val == '0) begin
          r.status = ST_NULL;
        end else begin
          r.status = ST_NOT_FOUND;
          for (int i = 0; i < list_len; i++) begin
            if (r.status == ST_NOT_FOUND && list_vals[i] == val) begin
              r.status = ST_OK;
              r.found  = FOUND_W'(i);
            end
          end
        end
      end
    endcase
    r.length = LEN_W'(list_len);
    return r;
  endfunction

  // called at a falling edge, returns at the falling edge after the transfer
  task automatic send_item(op_e op, int idx, logic [DATA_W-1:0] val);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {1'b0, val, IDX_W'(idx), op};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_results.push_back(apply_list_op(op, IDX_W'(idx), val));
    @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
  end

  always @(posedge clk_i) begin
    list_result_t      want;
    logic [2:0]        got_status;
    logic [DATA_W-1:0] got_removed;
    logic [FOUND_W-1:0] got_found;
    logic [LEN_W-1:0]  got_length;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got_status  = m_axis_tdata[2:0];
      got_removed = m_axis_tdata[34:3];
      got_found   = m_axis_tdata[38:35];
      got_length  = m_axis_tdata[43:39];
      if (pending_results.size() == 0) begin
        $error("result transfer with no expected result pending");
        fail_count++;
      end else begin
        want = pending_results.pop_front();
        if (got_status != want.status) begin
          $error("status: expected %0d, actual %0d", want.status, got_status);
          fail_count++;
        end
        if (got_removed != want.removed) begin
          $error("removed_value: expected %h, actual %h", want.removed, got_removed);
          fail_count++;
        end
        if (got_found != want.found) begin
          $error("found_index: expected %0d, actual %0d", want.found, got_found);
          fail_count++;
        end
        if (got_length != want.length) begin
          $error("length: expected %0d, actual %0d", want.length, got_length);
          fail_count++;
        end
      end
    end
  end

  task automatic test_empty_list_cases();
    send_item(OP_REMOVE, 0, 32'h0000_0001);
    send_item(OP_FIND, 0, 32'h0000_0005);
    send_item(OP_FIND, 3, 32'h0000_0000);
    send_item(OP_PUSH, 0, 32'h0000_0000);
    send_item(OP_INSERT, 1, 32'h0000_0007);
    // bad index wins over null value
    send_item(OP_INSERT, 1, 32'h0000_0000);
    send_item(OP_INSERT, 0, 32'h0000_0000);
  endtask

  task automatic test_insert_remove_find();
    send_item(OP_INSERT, 0, 32'hFFFF_FFFF);
    send_item(OP_PUSH, 16, 32'h0000_0001);
    send_item(OP_INSERT, 2, 32'h8000_0000);
    send_item(OP_INSERT, 1, 32'h1234_5678);
    send_item(OP_FIND, 16, 32'hFFFF_FFFF);
    send_item(OP_FIND, 0, 32'h8000_0000);
    send_item(OP_REMOVE, 4, 32'h0000_0000);
    send_item(OP_REMOVE, 16, 32'h0000_0000);
    send_item(OP_REMOVE, 1, 32'hFFFF_FFFF);
  endtask

  task automatic test_full_list();
    while (list_len < LIST_DEPTH) send_item(OP_PUSH, 0, value_pool[$urandom_range(0, 7)]);
    send_item(OP_PUSH, 0, 32'h0000_0005);
    send_item(OP_INSERT, 16, 32'h0000_0009);
    send_item(OP_INSERT, 16, 32'h0000_0000);
    send_item(OP_INSERT, 0, 32'h0000_0003);
    send_item(OP_FIND, 0, list_vals[LIST_DEPTH-1]);
    send_item(OP_REMOVE, 15, 32'h0000_0000);
    send_item(OP_REMOVE, 0, 32'h0000_0000);
  endtask

  task automatic send_random_item();
    int                r;
    int                idx;
    op_e               op;
    logic [DATA_W-1:0] val;
    r = $urandom_range(0, 99);
    if (grow_bias) begin
      op = (r < 40) ? OP_PUSH : (r < 75) ? OP_INSERT : (r < 88) ? OP_REMOVE : OP_FIND;
    end else begin
      op = (r < 12) ? OP_PUSH : (r < 25) ? OP_INSERT : (r < 75) ? OP_REMOVE : OP_FIND;
    end
    if ($urandom_range(0, 99) < 15) begin
      idx = $urandom_range(0, LIST_DEPTH);
    end else if (op == OP_REMOVE && list_len > 0) begin
      idx = $urandom_range(0, list_len - 1);
    end else begin
      idx = $urandom_range(0, list_len);
    end
    r = $urandom_range(0, 99);
    if (r < 5) begin
      val = '0;
    end else if (op == OP_FIND && list_len > 0 && r < 65) begin
      val = list_vals[$urandom_range(0, list_len - 1)];
    end else if (r < 40) begin
      val = value_pool[$urandom_range(0, 7)];
    end else begin
      val = $urandom;
    end
    send_item(op, idx, val);
  endtask

  task automatic test_random_traffic(int n_items, int src_pct, int snk_pct);
    src_idle_pct  = src_pct;
    snk_stall_pct = snk_pct;
    for (int k = 0; k < n_items; k++) begin
      if ($urandom_range(0, 29) == 0) grow_bias = ~grow_bias;
      send_random_item();
    end
  endtask

  initial begin
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    fail_count    = 0;
    list_len      = 0;
    src_idle_pct  = 0;
    snk_stall_pct = 0;
    grow_bias     = 1'b1;
    value_pool    = '{32'h0000_0001, 32'hFFFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF,
                      32'h0000_00AA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0100};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_empty_list_cases();
    test_insert_remove_find();
    test_full_list();
    test_random_traffic(110, 0, 0);
    test_random_traffic(110, 71, 0);
    test_random_traffic(110, 0, 71);
    test_random_traffic(110, 32, 32);
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("indexed_insert_remove_list_unit regression: pass");
    end else begin
      $display("indexed_insert_remove_list_unit regression: fail");
    end
    $finish;
  end

endmodule
